@@ design/itd_pkg.sv @@
// Shared constants for the incremental tree diameter block.
`default_nettype none
package itd_pkg;
    localparam int DATA_W     = 16;
    localparam int INIT_NODES = 4;
    localparam int ROOT_NODE  = 1;
    localparam int INIT_END_A = 2;
    localparam int INIT_END_B = 3;
    localparam int INIT_DIAM  = 2;
    localparam int ROOT_DEPTH = 1;
endpackage
`default_nettype wire

@@ design/itd_store.sv @@
// Node store: parent, depth and ancestor memories with the initial tree in fixed logic.
`default_nettype none
module itd_store #(
    parameter int MAX_NODES = 65536,
    parameter int LEVELS    = 16
) (
    input  wire logic                          i_clk,
    input  wire logic [$clog2(MAX_NODES)-1:0]  i_rd_node,
    input  wire logic [$clog2(LEVELS)-1:0]     i_rd_lvl,
    input  wire logic                          i_wr_node_en,
    input  wire logic [$clog2(MAX_NODES)-1:0]  i_wr_node,
    input  wire logic [$clog2(MAX_NODES)-1:0]  i_wr_parent,
    input  wire logic [$clog2(MAX_NODES)-1:0]  i_wr_depth,
    input  wire logic                          i_wr_anc_en,
    input  wire logic [$clog2(LEVELS)-1:0]     i_wr_anc_lvl,
    input  wire logic [$clog2(MAX_NODES)-1:0]  i_wr_anc_data,
    output logic      [$clog2(MAX_NODES)-1:0]  o_parent,
    output logic      [$clog2(MAX_NODES)-1:0]  o_depth,
    output logic      [$clog2(MAX_NODES)-1:0]  o_anc
);
    localparam int NW = $clog2(MAX_NODES);
    localparam int LW = $clog2(LEVELS);
    localparam int AW = $clog2(MAX_NODES * LEVELS);

    logic [NW-1:0] mem_par [MAX_NODES];
    logic [NW-1:0] mem_dep [MAX_NODES];
    logic [NW-1:0] mem_anc [MAX_NODES * LEVELS];

    logic [NW-1:0] r_par_q;
    logic [NW-1:0] r_dep_q;
    logic [NW-1:0] r_anc_q;
    logic [NW-1:0] r_rd_node;
    logic [LW-1:0] r_rd_lvl;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    assign rd_addr = AW'(i_rd_node) * AW'(LEVELS) + AW'(i_rd_lvl);
    assign wr_addr = AW'(i_wr_node) * AW'(LEVELS) + AW'(i_wr_anc_lvl);

    always_ff @(posedge i_clk) begin
        if (i_wr_node_en) begin
            mem_par[i_wr_node] <= i_wr_parent;
            mem_dep[i_wr_node] <= i_wr_depth;
        end
        if (i_wr_anc_en) begin
            mem_anc[wr_addr] <= i_wr_anc_data;
        end
        r_par_q   <= mem_par[i_rd_node];
        r_dep_q   <= mem_dep[i_rd_node];
        r_anc_q   <= mem_anc[rd_addr];
        r_rd_node <= i_rd_node;
        r_rd_lvl  <= i_rd_lvl;
    end

    // Nodes of the initial tree are never written, so their entries come from fixed logic.
    always_comb begin
        if (r_rd_node == '0) begin
            o_parent = '0;
            o_depth  = '0;
            o_anc    = '0;
        end else if (r_rd_node == NW'(itd_pkg::ROOT_NODE)) begin
            o_parent = '0;
            o_depth  = NW'(itd_pkg::ROOT_DEPTH);
            o_anc    = '0;
        end else if (r_rd_node <= NW'(itd_pkg::INIT_NODES)) begin
            o_parent = NW'(itd_pkg::ROOT_NODE);
            o_depth  = NW'(itd_pkg::ROOT_DEPTH + 1);
            o_anc    = (r_rd_lvl == '0) ? NW'(itd_pkg::ROOT_NODE) : '0;
        end else begin
            o_parent = r_par_q;
            o_depth  = r_dep_q;
            o_anc    = r_anc_q;
        end
    end
endmodule
`default_nettype wire

@@ design/incremental_tree_diameter_core.sv @@
// Top level: sequencer that grows the tree, walks common ancestors and tracks the diameter.
// An accepted item makes two leaf inserts and two ancestor walks, all sharing the single
// read port of the node store. A refused item makes no insert and no walk.
// The input is not ready while an item is at work; the result waits in an output register.
// Synchronous reset restores the four-node starting tree at once, with no clearing pass.
`default_nettype none
module incremental_tree_diameter_core #(
    parameter int MAX_NODES = 65536,
    parameter int LEVELS    = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // parent_node
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [15:0] o_m_tdata,   // diameter
    output logic      [0:0]  o_m_tuser    // error
);
    localparam int NW = $clog2(MAX_NODES);
    localparam int LW = $clog2(LEVELS);
    localparam int PW = NW + 1;
    localparam int CW = ((NW > LEVELS) ? NW : LEVELS) + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_AT_ISS, S_AT_DEP, S_AT_LWR,
        S_L_RDA, S_L_RDB, S_L_SWAP, S_L_LIFT, S_L_LIFTW, S_L_EQ,
        S_L_CA, S_L_CB, S_L_CD, S_L_PAR, S_L_PARW, S_L_DEPC
    } t_state;

    t_state        r_state;
    logic [NW-1:0] r_nc;
    logic [NW-1:0] r_end_a;
    logic [NW-1:0] r_end_b;
    logic [PW-1:0] r_diam;
    logic [NW-1:0] r_up;
    logic [NW-1:0] r_node;
    logic          r_second;
    logic [LW-1:0] r_k;
    logic [NW-1:0] r_a;
    logic [NW-1:0] r_b;
    logic [NW-1:0] r_da0;
    logic [NW-1:0] r_db0;
    logic [NW-1:0] r_dca;
    logic [NW-1:0] r_dcb;
    logic [LW-1:0] r_i;
    logic [NW-1:0] r_ua;
    logic          r_pass;
    logic [PW-1:0] r_pa;
    logic          r_m_tvalid;
    logic [15:0]   r_m_tdata;
    logic          r_m_tuser;

    logic [NW-1:0] rd_node;
    logic [LW-1:0] rd_lvl;
    logic          wr_node_en;
    logic          wr_anc_en;
    logic [LW-1:0] wr_anc_lvl;
    logic [NW-1:0] wr_anc_data;
    logic [NW-1:0] st_par;
    logic [NW-1:0] st_dep;
    logic [NW-1:0] st_anc;

    logic          accept;
    logic          in_err;
    logic [31:0]   p32;
    logic [CW-1:0] step;
    logic          lift;
    logic signed [NW+2:0] path_s;
    logic [PW-1:0] path;
    logic [PW-1:0] n_diam;
    logic          upd_b;
    logic          upd_a;

    itd_store #(
        .MAX_NODES(MAX_NODES),
        .LEVELS   (LEVELS)
    ) u_store (
        .i_clk        (i_clk),
        .i_rd_node    (rd_node),
        .i_rd_lvl     (rd_lvl),
        .i_wr_node_en (wr_node_en),
        .i_wr_node    (r_node),
        .i_wr_parent  (r_up),
        .i_wr_depth   (st_dep + NW'(1)),
        .i_wr_anc_en  (wr_anc_en),
        .i_wr_anc_lvl (wr_anc_lvl),
        .i_wr_anc_data(wr_anc_data),
        .o_parent     (st_par),
        .o_depth      (st_dep),
        .o_anc        (st_anc)
    );

    function automatic logic [15:0] sat16(input logic [PW-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    assign o_s_tready = (r_state == S_IDLE) && (!r_m_tvalid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    assign p32    = 32'(i_s_tdata);
    assign in_err = (p32 == 32'd0) || (p32 > 32'(r_nc))
                 || (32'(r_nc) + 32'd2 > 32'(MAX_NODES - 1));

    assign step = CW'(1) << r_i;
    assign lift = (CW'(r_dca) >= CW'(r_dcb) + step);

    assign path_s = $signed((NW+3)'(r_da0)) + $signed((NW+3)'(r_db0))
                  - $signed((NW+3)'({st_dep, 1'b0}));
    assign path   = (path_s < 0) ? '0 : PW'(path_s);

    assign upd_b  = (r_pa >= path) && (r_pa > r_diam);
    assign upd_a  = !upd_b && (path >= r_pa) && (path > r_diam);
    assign n_diam = upd_b ? r_pa : (upd_a ? path : r_diam);

    always_comb begin
        rd_node = r_a;
        rd_lvl  = '0;
        unique case (r_state)
            S_IDLE:    rd_node = NW'(i_s_tdata);
            S_AT_ISS:  rd_node = r_up;
            S_AT_DEP:  rd_node = r_up;
            S_AT_LWR: begin
                rd_node = st_anc;
                rd_lvl  = r_k;
            end
            S_L_RDB:   rd_node = r_b;
            S_L_LIFT:  rd_lvl  = r_i;
            S_L_CA:    rd_lvl  = r_i;
            S_L_CB: begin
                rd_node = r_b;
                rd_lvl  = r_i;
            end
            S_L_PARW:  rd_node = st_par;
            default:   rd_node = r_a;
        endcase
    end

    assign wr_node_en  = (r_state == S_AT_DEP);
    assign wr_anc_en   = (r_state == S_AT_DEP) || (r_state == S_AT_LWR);
    assign wr_anc_lvl  = (r_state == S_AT_DEP) ? '0 : r_k;
    assign wr_anc_data = (r_state == S_AT_DEP) ? r_up : st_anc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_nc       <= NW'(itd_pkg::INIT_NODES);
            r_end_a    <= NW'(itd_pkg::INIT_END_A);
            r_end_b    <= NW'(itd_pkg::INIT_END_B);
            r_diam     <= PW'(itd_pkg::INIT_DIAM);
            r_m_tvalid <= 1'b0;
        end else begin
            if (r_m_tvalid && i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (in_err) begin
                            r_m_tvalid <= 1'b1;
                            r_m_tdata  <= sat16(r_diam);
                            r_m_tuser  <= 1'b1;
                        end else begin
                            r_up     <= NW'(i_s_tdata);
                            r_node   <= r_nc + NW'(1);
                            r_second <= 1'b0;
                            r_state  <= S_AT_DEP;
                        end
                    end
                end
                S_AT_ISS: r_state <= S_AT_DEP;
                S_AT_DEP: begin
                    r_k     <= LW'(1);
                    r_state <= S_AT_LWR;
                end
                S_AT_LWR: begin
                    if (r_k == LW'(LEVELS - 1)) begin
                        if (!r_second) begin
                            r_second <= 1'b1;
                            r_node   <= r_node + NW'(1);
                            r_state  <= S_AT_ISS;
                        end else begin
                            r_nc    <= r_node;
                            r_a     <= r_node;
                            r_b     <= r_end_a;
                            r_pass  <= 1'b0;
                            r_state <= S_L_RDA;
                        end
                    end else begin
                        r_k <= r_k + LW'(1);
                    end
                end
                S_L_RDA: r_state <= S_L_RDB;
                S_L_RDB: begin
                    r_da0   <= st_dep;
                    r_state <= S_L_SWAP;
                end
                S_L_SWAP: begin
                    r_db0 <= st_dep;
                    if (r_da0 < st_dep) begin
                        r_a   <= r_b;
                        r_b   <= r_a;
                        r_dca <= st_dep;
                        r_dcb <= r_da0;
                    end else begin
                        r_dca <= r_da0;
                        r_dcb <= st_dep;
                    end
                    r_i     <= LW'(LEVELS - 1);
                    r_state <= S_L_LIFT;
                end
                S_L_LIFT: begin
                    if (lift) begin
                        r_dca   <= NW'(CW'(r_dca) - step);
                        r_state <= S_L_LIFTW;
                    end else if (r_i == '0) begin
                        r_state <= S_L_EQ;
                    end else begin
                        r_i <= r_i - LW'(1);
                    end
                end
                S_L_LIFTW: begin
                    r_a <= st_anc;
                    if (r_i == '0) begin
                        r_state <= S_L_EQ;
                    end else begin
                        r_i     <= r_i - LW'(1);
                        r_state <= S_L_LIFT;
                    end
                end
                S_L_EQ: begin
                    if (r_a == r_b) begin
                        r_state <= S_L_DEPC;
                    end else begin
                        r_i     <= LW'(LEVELS - 1);
                        r_state <= S_L_CA;
                    end
                end
                S_L_CA: r_state <= S_L_CB;
                S_L_CB: begin
                    r_ua    <= st_anc;
                    r_state <= S_L_CD;
                end
                S_L_CD: begin
                    if (r_ua != '0 && r_ua != st_anc) begin
                        r_a <= r_ua;
                        r_b <= st_anc;
                    end
                    if (r_i == '0) begin
                        r_state <= S_L_PAR;
                    end else begin
                        r_i     <= r_i - LW'(1);
                        r_state <= S_L_CA;
                    end
                end
                S_L_PAR:  r_state <= S_L_PARW;
                S_L_PARW: r_state <= S_L_DEPC;
                S_L_DEPC: begin
                    if (!r_pass) begin
                        r_pa    <= path;
                        r_a     <= r_nc;
                        r_b     <= r_end_b;
                        r_pass  <= 1'b1;
                        r_state <= S_L_RDA;
                    end else begin
                        if (upd_b) begin
                            r_end_b <= r_nc;
                        end
                        if (upd_a) begin
                            r_end_a <= r_nc;
                        end
                        r_diam     <= n_diam;
                        r_m_tvalid <= 1'b1;
                        r_m_tdata  <= sat16(n_diam);
                        r_m_tuser  <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
